>>> hw/rtl/dwmd_pkg.sv
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared constants and types of the distinct window marker detector.
// ----------------------------------------------------------------------------
package dwmd_pkg;

    localparam int MAX_WINDOW_DEF    = 16;
    localparam int POSITION_BITS_DEF = 24;

    // window_size register
    localparam int             CFG_W             = 5;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd4;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // control from the stream logic to the window tracker
    typedef struct packed {
        logic step;   // take the current byte into the window
        logic clear;  // restart the window for a new stream
    } win_ctrl_t;

endpackage

>>> hw/rtl/dwmd_window.sv
// ----------------------------------------------------------------------------
// dwmd_window
// Byte history and length of the all-distinct run ending at the newest byte.
// ----------------------------------------------------------------------------
module dwmd_window #(
    parameter int   MAX_WINDOW = dwmd_pkg::MAX_WINDOW_DEF,
    localparam int  LW = $clog2(MAX_WINDOW + 1),
    localparam int  NW = (LW > dwmd_pkg::CFG_W) ? LW : dwmd_pkg::CFG_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dwmd_pkg::win_ctrl_t ctrl,
    input  logic [7:0]          data_byte,
    input  logic [NW-1:0]       window_len,
    output logic                hit
);
    import dwmd_pkg::*;

    logic [7:0]    hist_reg [MAX_WINDOW];
    logic [LW-1:0] run_reg;
    logic [LW-1:0] run_next;
    logic [LW:0]   run_inc;
    logic [LW:0]   run_cap;
    logic [LW:0]   run_new;

    // nearest earlier copy of the byte limits the distinct run
    always_comb
    begin
        run_cap = (LW+1)'(MAX_WINDOW);
        for (int i = MAX_WINDOW - 1; i >= 0; i--)
        begin
            if (hist_reg[i] == data_byte)
            begin
                run_cap = (LW+1)'(i + 1);
            end
        end
        run_inc = {1'b0, run_reg} + 1'b1;
        run_new = (run_inc < run_cap) ? run_inc : run_cap;
        hit     = ((NW+1)'(run_new) >= (NW+1)'(window_len));
        if (ctrl.clear)
        begin
            run_next = '0;
        end
        else if (ctrl.step)
        begin
            run_next = run_new[LW-1:0];
        end
        else
        begin
            run_next = run_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    // newest byte at index 0; stale bytes are masked by the run length
    always_ff @(posedge clk)
    begin
        if (ctrl.step && !ctrl.clear)
        begin
            hist_reg[0] <= data_byte;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule

>>> hw/rtl/distinct_window_marker_detector.sv
// ----------------------------------------------------------------------------
// distinct_window_marker_detector
// Finds the first point of a byte stream where the last window_size bytes
// are all different and reports its position, else the stream length.
// ----------------------------------------------------------------------------
// result: each byte is held in the input register, then its result in the result register
// throughput: one byte per cycle while the output is not held off; the byte is
//   compared against the whole history register in one pass, so the run length updates with each step
// reset: window_size returns to 4, the stream state clears at once, no
//   clearing pass; a window_size write also restarts the stream
module distinct_window_marker_detector #(
    parameter int MAX_WINDOW    = dwmd_pkg::MAX_WINDOW_DEF,
    parameter int POSITION_BITS = dwmd_pkg::POSITION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // [7:0] data_byte
    input  logic                                 s_tlast,  // end_of_stream
    // master stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [8*((POSITION_BITS+7)/8)-1:0]   m_tdata,  // position, zero padded
    output logic                                 m_tuser,  // [0] marker_found
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import dwmd_pkg::*;

    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int NW = (LW > CFG_W) ? LW : CFG_W;
    localparam int DW = 8 * ((POSITION_BITS + 7) / 8);

    logic [CFG_W-1:0]         ws_reg;
    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;
    logic [POSITION_BITS-1:0] seen_reg;
    logic [POSITION_BITS-1:0] seen_inc;
    logic                     done_reg;
    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic [POSITION_BITS-1:0] out_pos_reg;

    logic                     cfg_write;
    logic                     advance;
    logic                     hit;
    logic                     found;
    logic                     produce;
    logic [NW-1:0]            ws_ext;
    logic [NW-1:0]            window_len;
    win_ctrl_t                win_ctrl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? 32'(ws_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_write && paddr[2] == REG_WINDOW_SIZE)
        begin
            ws_reg <= pwdata[CFG_W-1:0];
        end
    end

    // zero acts as one, large values clip to the history depth
    always_comb
    begin
        ws_ext = NW'(ws_reg);
        if (ws_reg == '0)
        begin
            window_len = NW'(1);
        end
        else if (ws_ext > NW'(MAX_WINDOW))
        begin
            window_len = NW'(MAX_WINDOW);
        end
        else
        begin
            window_len = ws_ext;
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    assign found    = advance && !done_reg && hit;
    assign produce  = advance && !done_reg && (hit || in_last_reg);

    assign win_ctrl.step  = advance && !done_reg;
    assign win_ctrl.clear = (advance && in_last_reg) || cfg_write;

    dwmd_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .data_byte  (in_byte_reg),
        .window_len (window_len),
        .hit        (hit)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (win_ctrl.clear)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (win_ctrl.step)
        begin
            seen_reg <= seen_inc;
            done_reg <= found;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_found_reg <= hit;
            out_pos_reg   <= seen_inc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = DW'(out_pos_reg);

    // a marker is always reported on the cycle it is latched
    a_done_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> out_valid_reg && out_found_reg)
        else $error("marker latched without a found result");

    // bytes after the marker never create a result
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && done_reg |=> !out_valid_reg)
        else $error("result produced after marker");

    // a byte inside a stream before the marker always advances the length counter
    a_seen_counts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_last_reg && !done_reg && !cfg_write |=> seen_reg != '0)
        else $error("stream length not counted");

    // a clear leaves the stream re-armed
    a_clear_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        win_ctrl.clear |=> !done_reg && seen_reg == '0)
        else $error("stream state not cleared");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for distinct_window_marker_detector: byte streams go
// in on the slave side, found / not-found results are checked on the master
// side against a cycle-free model of the window, over several window sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import dwmd_pkg::*;

    localparam int HIST_DEPTH   = MAX_WINDOW_DEF;
    localparam int LONG_STALL   = 300;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 170;

    typedef struct {
        logic [7:0] data_byte;
        logic       end_of_stream;
        int         gap;
    } stream_beat_t;

    typedef struct {
        logic        marker_found;
        logic [23:0] position;
    } marker_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;   // end_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [23:0] position
    logic        m_tuser;          // [0] marker_found
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    distinct_window_marker_detector u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    stream_beat_t   pending_beats[$];
    marker_result_t expected_markers[$];

    // window model
    logic [7:0]  win_hist [HIST_DEPTH];
    int          win_counts [256];
    int          distinct_vals;
    int          wr_ptr;
    logic [23:0] stream_len;
    bit          marker_seen;
    logic [4:0]  window_cfg = WINDOW_SIZE_RESET;

    int  error_count = 0;
    int  cycle_count = 0;
    int  bytes_accepted = 0;
    int  found_count = 0;
    int  not_found_count = 0;
    int  settings_used = 1;
    int  queued_bytes = 0;
    bit  tx_no_idle = 1'b0;
    bit  rx_no_idle = 1'b0;
    int  long_stall_ticket = 0;
    int  long_stall_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  gap_count = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int window_len(input logic [4:0] w);
        if (w == 5'd0)
            return 1;
        if (w > HIST_DEPTH)
            return HIST_DEPTH;
        return int'(w);
    endfunction

    task automatic clear_stream_state();
        foreach (win_hist[i])
            win_hist[i] = 8'h00;
        foreach (win_counts[i])
            win_counts[i] = 0;
        distinct_vals = 0;
        wr_ptr = 0;
        stream_len = '0;
        marker_seen = 1'b0;
    endtask

    task automatic predict_marker(input logic [7:0] b, input logic eos);
        int             n;
        logic [7:0]     old_byte;
        marker_result_t res;
        n = window_len(window_cfg);
        if (!marker_seen)
        begin
            // drop the byte that slides out of the window
            if (stream_len >= n)
            begin
                old_byte = win_hist[(wr_ptr + HIST_DEPTH - n) % HIST_DEPTH];
                if (win_counts[old_byte] > 0)
                begin
                    win_counts[old_byte]--;
                    if (win_counts[old_byte] == 0 && distinct_vals > 0)
                        distinct_vals--;
                end
            end
            win_hist[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
            win_counts[b]++;
            if (win_counts[b] == 1)
                distinct_vals++;
            if (stream_len != 24'hFF_FFFF)
                stream_len++;
            if (stream_len >= n && distinct_vals == n)
            begin
                marker_seen = 1'b1;
                res.marker_found = 1'b1;
                res.position = stream_len;
                expected_markers.push_back(res);
            end
            else if (eos)
            begin
                res.marker_found = 1'b0;
                res.position = stream_len;
                expected_markers.push_back(res);
            end
        end
        if (eos)
            clear_stream_state();
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eos);
        stream_beat_t beat;
        beat.data_byte = b;
        beat.end_of_stream = eos;
        beat.gap = tx_no_idle ? 0 : $urandom_range(0, 17);
        pending_beats.push_back(beat);
        queued_bytes++;
    endtask

    // one stream: mostly bytes from a small alphabet sized around the window,
    // the rest pure noise, near-constant runs, or a distinct opening window
    task automatic queue_stream(input int n);
        logic [7:0] alphabet[$];
        logic [7:0] pick;
        int         kind;
        int         k;
        int         len;
        bit         dup;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            k = $urandom_range(n > 1 ? n - 1 : 1, n + 2);
            len = $urandom_range(1, 3 * n + 8);
        end
        else if (kind == 7)
        begin
            k = 1;
            len = $urandom_range(1, 40);
        end
        else if (kind == 8)
        begin
            k = $urandom_range(1, 3);
            len = $urandom_range(1, 24);
        end
        else
        begin
            k = n;
            len = n + $urandom_range(0, 10);
        end
        while (alphabet.size() < k)
        begin
            pick = 8'($urandom_range(0, 255));
            dup = 1'b0;
            foreach (alphabet[i])
                if (alphabet[i] == pick)
                    dup = 1'b1;
            if (!dup)
                alphabet.push_back(pick);
        end
        for (int i = 0; i < len; i++)
        begin
            if (kind == 7)
                pick = 8'($urandom_range(0, 255));
            else if (kind == 9 && i < n)
                pick = alphabet[i];
            else
                pick = alphabet[$urandom_range(0, k - 1)];
            queue_byte(pick, i == len - 1);
        end
    endtask

    // everything sent, every result back, plus the pipeline's latency
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_tvalid || expected_markers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [4:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= {27'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a window_size write restarts the stream
        window_cfg = value;
        clear_stream_state();
        settings_used++;
    endtask

    task automatic cfg_read_check(input logic [4:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {27'd0, value})
        begin
            $error("window_size readback: expected %0d, actual %0d", value, prdata);
            error_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // slave side driver
    always @(posedge clk)
    begin : tx_side
        stream_beat_t beat;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            gap_count <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_beats.size() == 0)
                s_tvalid <= 1'b0;
            else if (gap_count < pending_beats[0].gap)
            begin
                s_tvalid  <= 1'b0;
                gap_count <= gap_count + 1;
            end
            else
            begin
                beat = pending_beats.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= beat.data_byte;
                s_tlast   <= beat.end_of_stream;
                gap_count <= 0;
            end
        end
    end

    // master side ready, with per-result stalls and an occasional long hold
    always @(posedge clk)
    begin : rx_side
        int draw;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            stall_left <= 0;
        end
        else if (long_stall_ticket != long_stall_served)
        begin
            long_stall_served <= long_stall_ticket;
            hold_left <= LONG_STALL;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            draw = rx_no_idle ? 0 : $urandom_range(0, 17);
            stall_left <= draw;
            m_tready   <= (draw == 0);
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            if (m_tvalid)
                stall_left <= stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin : monitor
        marker_result_t exp_res;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_marker(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_markers.size() == 0)
                begin
                    $error("unexpected result: marker_found %0d position %0d",
                           m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_markers.pop_front();
                    if (m_tuser !== exp_res.marker_found)
                    begin
                        $error("marker_found: expected %0d, actual %0d",
                               exp_res.marker_found, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== exp_res.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               exp_res.position, m_tdata);
                        error_count++;
                    end
                    if (exp_res.marker_found)
                        found_count++;
                    else
                        not_found_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_markers.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [4:0] win;
        clear_stream_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        cfg_read_check(WINDOW_SIZE_RESET);

        // directed streams at the reset window of 4
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h22, 1'b1);    // after the marker: ignored, only re-arms
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b1);    // marker on the end-of-stream byte
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b1);
        repeat (4) queue_byte(8'h09, 1'b0);
        queue_byte(8'h09, 1'b1);
        // half a stream, then a register write that must restart it
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        wait_idle();
        cfg_write(5'd2);
        cfg_read_check(5'd2);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h33, 1'b0);
        queue_byte(8'h33, 1'b0);
        queue_byte(8'h34, 1'b1);
        wait_idle();

        // back-pressure: one result per byte while the output is held off
        cfg_write(5'd1);
        tx_no_idle = 1'b1;
        long_stall_ticket++;
        for (int i = 0; i < 60; i++)
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        tx_no_idle = 1'b0;

        // random phases over several window settings, extremes included
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: win = 5'd16;
                1: win = 5'd0;
                2: win = 5'd31;
                3: win = 5'd17;
                4: win = 5'd1;
                5: win = 5'd5;
                6: win = 5'd8;
                9: win = 5'd3;
                default: win = 5'($urandom_range(0, 31));
            endcase
            cfg_write(win);
            cfg_read_check(win);
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            queued_bytes = 0;
            while (queued_bytes < PHASE_BYTES)
                queue_stream(window_len(win));
            wait_idle();
        end

        $display("covered %0d bytes over %0d window settings: %0d markers found,",
                 bytes_accepted, settings_used, found_count);
        $display("  %0d streams ended without one, in %0d cycles",
                 not_found_count, cycle_count);
        if (error_count == 0 && expected_markers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/dwmd_pkg.sv
hw/rtl/dwmd_window.sv
hw/rtl/distinct_window_marker_detector.sv
sim/tb.sv
